@@ rtl/vpd_pkg.sv @@
package vpd_pkg;

   // Decoder phase: length varint, id varint, payload bytes, stopped after an error.
   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_ID   = 2'd1,
      PH_DATA = 2'd2,
      PH_DEAD = 2'd3
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes.
   localparam logic ERR_TOO_LONG = 1'b0;
   localparam logic ERR_TOO_BIG  = 1'b1;

   // A varint holds at most this many bytes.
   localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

   // Reset value of the payload size limit.
   localparam logic [30:0] MAX_PAYLOAD_RESET = 31'd32767;

   // Decoder state carried from one byte to the next.
   typedef struct packed {
      phase_type   phase;
      logic [31:0] accumulator;
      logic [2:0]  byte_count;
      logic [31:0] frame_length;
      logic [30:0] payload_left;
   } state_type;

   // One result item.
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] header_id;
      logic [30:0]        payload_length;
      logic [7:0]         data_byte;
      logic               last;
      logic               error_code;
   } result_type;

endpackage

@@ rtl/varint_packet_deframer.sv @@
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_in_byte
// rsp       out        rsp_valid/rsp_stall   kind, header_id, payload_length, data_byte,
//                                            last, error_code
// csr       in         csr_write_enable      csr_write_data (max_payload_bytes)
//
// One byte is taken every cycle while req_stall is low; a result passes through the input
// register, the decode and then the result register after its byte transfer.
// Synchronous reset clears the phase, the varint state and both valid flags,
// and restores the payload limit to 32767.
// A stalled result holds the result register; the input register then holds too
// and req_stall rises only while it carries a byte.
module varint_packet_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_header_id,
   output logic [30:0]        rsp_payload_length,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_last,
   output logic               rsp_error_code,
   input  logic               csr_write_enable,
   input  logic [30:0]        csr_write_data
);
   import vpd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   state_type   state_ff;
   state_type   state_in;
   logic [30:0] max_payload_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;
   result_type  result_in;
   logic        has_result;
   logic        out_blocked;
   logic        fire;

   assign out_blocked = rsp_valid_ff & rsp_stall;
   assign fire        = in_valid_ff & ~out_blocked;
   assign req_stall   = in_valid_ff & out_blocked;

   // Payload size limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write_enable) begin
         max_payload_ff <= csr_write_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // Decode of one byte.
   vpd_step u_step (
      .state_cur         (state_ff),
      .in_byte           (in_byte_ff),
      .max_payload_bytes (max_payload_ff),
      .state_nxt         (state_in),
      .has_result        (has_result),
      .result            (result_in)
   );

   // Decoder state advances once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= PH_LEN;
         state_ff.accumulator  <= 32'b0;
         state_ff.byte_count   <= 3'd0;
         state_ff.frame_length <= 32'b0;
         state_ff.payload_left <= 31'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_blocked) begin
         rsp_valid_ff <= fire & has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_header_id      = rsp_ff.header_id;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last           = rsp_ff.last;
   assign rsp_error_code     = rsp_ff.error_code;

endmodule

@@ rtl/vpd_step.sv @@
module vpd_step (
   input  vpd_pkg::state_type  state_cur,
   input  logic [7:0]          in_byte,
   input  logic [30:0]         max_payload_bytes,
   output vpd_pkg::state_type  state_nxt,
   output logic                has_result,
   output vpd_pkg::result_type result
);
   import vpd_pkg::*;

   logic [31:0] acc_bits;
   logic [31:0] acc_new;
   logic [2:0]  count_new;
   logic [33:0] plen;
   logic        too_big;

   // Place the low seven bits of the byte at bit 7*k; bits above 31 fall away.
   always_comb begin
      case (state_cur.byte_count)
         3'd0:    acc_bits = {25'b0, in_byte[6:0]};
         3'd1:    acc_bits = {18'b0, in_byte[6:0], 7'b0};
         3'd2:    acc_bits = {11'b0, in_byte[6:0], 14'b0};
         3'd3:    acc_bits = {4'b0, in_byte[6:0], 21'b0};
         3'd4:    acc_bits = {in_byte[3:0], 28'b0};
         default: acc_bits = 32'b0;
      endcase
   end

   assign acc_new   = state_cur.accumulator | acc_bits;
   assign count_new = state_cur.byte_count + 3'd1;

   // Payload length is the signed frame length less the id byte count, without wrap.
   assign plen    = {{2{state_cur.frame_length[31]}}, state_cur.frame_length}
                    - {31'b0, count_new};
   assign too_big = plen[33] | (plen[32:0] > {2'b0, max_payload_bytes});

   // Next state and result for one byte.
   always_comb begin
      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;
      case (state_cur.phase)
         PH_DATA: begin
            state_nxt.payload_left = state_cur.payload_left - 31'd1;
            has_result             = 1'b1;
            result.kind            = KIND_PAYLOAD;
            result.data_byte       = in_byte;
            if (state_cur.payload_left == 31'd1) begin
               state_nxt.phase = PH_LEN;
               result.last     = 1'b1;
            end
         end
         PH_LEN, PH_ID: begin
            if (in_byte[7]) begin
               if (count_new >= VARINT_MAX_BYTES) begin
                  state_nxt.phase   = PH_DEAD;
                  has_result        = 1'b1;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_TOO_LONG;
               end else begin
                  state_nxt.accumulator = acc_new;
                  state_nxt.byte_count  = count_new;
               end
            end else if (state_cur.phase == PH_LEN) begin
               state_nxt.frame_length = acc_new;
               state_nxt.accumulator  = 32'b0;
               state_nxt.byte_count   = 3'd0;
               state_nxt.phase        = PH_ID;
            end else begin
               // The id is complete: check the size and issue the header.
               state_nxt.accumulator = 32'b0;
               state_nxt.byte_count  = 3'd0;
               has_result            = 1'b1;
               if (too_big) begin
                  state_nxt.phase   = PH_DEAD;
                  result.kind       = KIND_ERROR;
                  result.error_code = ERR_TOO_BIG;
               end else begin
                  result.kind            = KIND_HEADER;
                  result.header_id       = acc_new;
                  result.payload_length  = plen[30:0];
                  state_nxt.payload_left = plen[30:0];
                  if (plen[30:0] == 31'd0) begin
                     state_nxt.phase = PH_LEN;
                     result.last     = 1'b1;
                  end else begin
                     state_nxt.phase = PH_DATA;
                  end
               end
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

@@ tb/varint_packet_deframer_checker.sv @@
`timescale 1ns / 1ps

module varint_packet_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_header_id,
   input  logic [30:0] rsp_payload_length,
   input  logic [7:0]  rsp_data_byte,
   input  logic        rsp_last,
   input  logic        rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [30:0] csr_write_data,
   output int          failures,
   output int          outstanding
);

   import vpd_pkg::*;

   // Predicted deframer state, and the size limit as last written.
   phase_type   phase_now;
   logic [31:0] accumulator;
   int          varint_bytes;
   logic [31:0] frame_length;
   logic [30:0] payload_left;
   logic [30:0] size_limit;

   // Results still owed by the block, oldest first.
   result_type  due_results[$];
   int          fail_count = 0;

   // Advances the predicted state by one stream byte and queues any result it causes.
   task automatic deframe_byte(input logic [7:0] in_byte);
      result_type  res;
      int          count;
      logic [31:0] id_value;
      longint      body_length;
      logic        emit;
      res  = '0;
      emit = 1'b0;
      if (phase_now == PH_DATA) begin
         payload_left  = payload_left - 31'd1;
         res.kind      = KIND_PAYLOAD;
         res.data_byte = in_byte;
         res.last      = (payload_left == 31'd0);
         if (payload_left == 31'd0) begin
            phase_now = PH_LEN;
         end
         emit = 1'b1;
      end else if (phase_now != PH_DEAD) begin
         // Groups beyond the fifth byte never land; the fifth keeps only four bits.
         count = varint_bytes;
         if (count < VARINT_MAX_BYTES) begin
            accumulator = accumulator | ({25'd0, in_byte[6:0]} << (7 * count));
         end
         count++;
         if (in_byte[7]) begin
            if (count >= VARINT_MAX_BYTES) begin
               phase_now      = PH_DEAD;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TOO_LONG;
               emit           = 1'b1;
            end else begin
               varint_bytes = count;
            end
         end else if (phase_now == PH_LEN) begin
            frame_length = accumulator;
            accumulator  = '0;
            varint_bytes = 0;
            phase_now    = PH_ID;
         end else begin
            // The id is complete: the frame length is signed and the id bytes count against it.
            id_value     = accumulator;
            accumulator  = '0;
            varint_bytes = 0;
            body_length  = longint'($signed(frame_length)) - longint'(count);
            if (body_length < 0 || body_length > longint'({1'b0, size_limit})) begin
               phase_now      = PH_DEAD;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_TOO_BIG;
            end else begin
               res.kind           = KIND_HEADER;
               res.header_id      = id_value;
               res.payload_length = body_length[30:0];
               res.last           = (body_length == 0);
               payload_left       = body_length[30:0];
               phase_now          = (body_length == 0) ? PH_LEN : PH_DATA;
            end
            emit = 1'b1;
         end
      end
      if (emit) begin
         due_results.push_back(res);
      end
   endtask

   function automatic int field_differs(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want === got) return 0;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      return 1;
   endfunction

   // Compares one result transfer with the oldest prediction.
   task automatic check_result();
      result_type want;
      if (due_results.size() == 0) begin
         $error("result with none expected: kind 0x%0h", rsp_kind);
         fail_count++;
      end else begin
         want = due_results.pop_front();
         fail_count += field_differs("kind", 64'(want.kind), 64'(rsp_kind));
         fail_count += field_differs("header_id", 64'($unsigned(want.header_id)),
                                     64'(rsp_header_id));
         fail_count += field_differs("payload_length", 64'(want.payload_length),
                                     64'(rsp_payload_length));
         fail_count += field_differs("data_byte", 64'(want.data_byte), 64'(rsp_data_byte));
         fail_count += field_differs("last", 64'(want.last), 64'(rsp_last));
         fail_count += field_differs("error_code", 64'(want.error_code),
                                     64'(rsp_error_code));
      end
   endtask

   // Everything is sampled at the rising edge; the counts go out as registered values.
   always @(posedge clock) begin
      if (reset) begin
         phase_now    = PH_LEN;
         accumulator  = '0;
         varint_bytes = 0;
         frame_length = '0;
         payload_left = '0;
         size_limit   = MAX_PAYLOAD_RESET;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (csr_write_enable) begin
            size_limit = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            deframe_byte(req_in_byte);
         end
      end
      failures    <= fail_count;
      outstanding <= due_results.size();
   end

endmodule

@@ tb/varint_packet_deframer_test.sv @@
`timescale 1ns / 1ps

module varint_packet_deframer_test;

   localparam int QUIET_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_in_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_header_id;
   logic [30:0]        rsp_payload_length;
   logic [7:0]         rsp_data_byte;
   logic               rsp_last;
   logic               rsp_error_code;
   logic               csr_write_enable = 1'b0;
   logic [30:0]        csr_write_data = 31'd0;

   int                 failures;
   int                 outstanding;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   int                 bytes_sent = 0;
   int                 quiet_cycles = 0;
   logic [30:0]        limit_now = vpd_pkg::MAX_PAYLOAD_RESET;

   varint_packet_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_header_id      (rsp_header_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_error_code     (rsp_error_code),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   varint_packet_deframer_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_header_id      (rsp_header_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_error_code     (rsp_error_code),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The result side stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Ends the run if neither channel completes a transfer for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offers one byte, idling first at the sender's rate, and returns once it is transferred.
   task automatic send_byte(input logic [7:0] value);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Shortest encoding of a value, sometimes padded with empty groups up to five bytes.
   function automatic int varint_width(input logic [31:0] value);
      int width;
      width = 1;
      while (width < 5 && (value >> (7 * width)) != 0) width++;
      if ($urandom_range(3) == 0) width = $urandom_range(5, width);
      return width;
   endfunction

   // Sends a value as a little-endian base-128 varint of the given length.
   task automatic send_varint(input logic [31:0] value, input int width);
      logic [7:0] group;
      for (int k = 0; k < width; k++) begin
         group = 8'((value >> (7 * k)) & 32'h7f);
         // The top three bits of a fifth group fall off the word, so fill them with noise.
         if (k == 4 && $urandom_range(1) == 1) group[6:4] = 3'($urandom_range(7));
         if (k < width - 1) group[7] = 1'b1;
         send_byte(group);
      end
   endtask

   task automatic send_packet(input int unsigned body, input logic [31:0] id);
      int          id_bytes;
      logic [31:0] frame;
      id_bytes = varint_width(id);
      frame    = body + id_bytes;
      send_varint(frame, varint_width(frame));
      send_varint(id, id_bytes);
      for (int i = 0; i < body; i++) send_byte(8'($urandom_range(255)));
   endtask

   // Mostly short payloads, some longer, some exactly at the limit when it is 48 or less; ids of every size.
   task automatic send_random_packet();
      int unsigned body;
      int unsigned pick;
      logic [31:0] id;
      pick = $urandom_range(99);
      if (pick < 65) body = $urandom_range(6);
      else if (pick < 92) body = $urandom_range(40, 7);
      else body = 32'(limit_now);
      if (body > limit_now) body = 32'(limit_now);
      if (body > 48) body = $urandom_range(48);
      case ($urandom_range(3))
         0: id = $urandom_range(127);
         1: id = $urandom_range(16383);
         default: id = $urandom();
      endcase
      send_packet(body, id);
   endtask

   // Holds the sender off until every predicted result has been transferred.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Writes the size limit once the block has drained and gone quiet.
   task automatic settle_and_write(input logic [30:0] value);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_now = value;
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct,
                            input logic [30:0] limit, input int budget);
      int start;
      settle_and_write(limit);
      idle_pct = sender_pct;
      stall_pct <= receiver_pct;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         send_random_packet();
         if ($urandom_range(29) == 0) wait_for_results();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A header-only packet: the frame covers just a one-byte id of zero.
      send_byte(8'h01);
      send_byte(8'h00);
      // An all-ones id in five bytes, followed by a payload of 0x00 and 0xff.
      send_byte(8'h07);
      send_varint(32'hffffffff, 5);
      send_byte(8'h00);
      send_byte(8'hff);
      // A padded five-byte frame length, and an id whose fifth byte has bits that drop off.
      send_byte(8'h86);
      send_byte(8'h80);
      send_byte(8'h80);
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'hff);
      send_byte(8'h77);
      send_byte(8'h80);
      // The most negative id with an empty payload.
      send_byte(8'h05);
      send_varint(32'h80000000, 5);

      // Random traffic under different limits and idling patterns.
      run_phase(0, 0, 31'h7fffffff, 100);
      run_phase(79, 0, 31'd0, 100);
      run_phase(0, 79, 31'($urandom_range(30, 1)), 100);
      run_phase(25, 25, 31'($urandom()), 100);

      // One fatal error to finish: the block then drops everything until reset.
      settle_and_write(31'($urandom_range(64)));
      case ($urandom_range(3))
         0: begin
            // Length varint running past five bytes.
            repeat (5) send_byte(8'h80 | 8'($urandom_range(127)));
         end
         1: begin
            // Id varint running past five bytes.
            send_byte(8'h03);
            repeat (5) send_byte(8'h80 | 8'($urandom_range(127)));
         end
         2: begin
            // Payload one byte above the limit.
            send_varint(32'(limit_now) + 32'd2, varint_width(32'(limit_now) + 32'd2));
            send_byte(8'($urandom_range(127)));
         end
         default: begin
            // Payload length below zero, from a short or a negative frame length.
            if ($urandom_range(1) == 1) send_byte(8'h00);
            else send_varint({1'b1, 31'($urandom())}, 5);
            send_byte(8'($urandom_range(127)));
         end
      endcase
      repeat (8) send_byte(8'($urandom_range(255)));

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
